### rtl/core/deadline_timer_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Deadline timer queue assertion macros
// Shared property forms for the checker of the timer queue core.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define DTQ_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTQ_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/dtq_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Sizes, request and result codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int IDX_W      = $clog2(NUM_TIMERS);
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
	localparam int REQ_W      = 2;
	localparam int ID_W       = 3;
	localparam int DELAY_W    = 32;
	localparam int TICK_W     = 64;
	localparam int TTN_W      = 31;
	localparam int KIND_W     = 2;

	localparam logic [REQ_W-1:0] REQ_START = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_YIELD = 2'd3;

	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

	typedef struct packed {
		logic              latch;
		logic              tick;
		logic              pos_clr;
		logic              pos_inc;
		logic              rem_shift;
		logic              ins_write;
		logic              emit;
		logic [KIND_W-1:0] emit_kind;
	} dtq_cmd_t;

	typedef struct packed {
		logic id_ok;
		logic at_end;
		logic found;
		logic ins_go;
		logic full;
		logic head_due;
		logic out_free;
	} dtq_sts_t;

endpackage

### rtl/core/dtq_intf.sv
// ----------------------------------------------------------------------------
// Deadline timer queue channels
// Request and result channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface dtq_req_if;
	logic                        valid;
	logic                        ready;
	logic [dtq_pkg::REQ_W-1:0]   req_type;
	logic [dtq_pkg::ID_W-1:0]    timer_id;
	logic [dtq_pkg::DELAY_W-1:0] delay;

	modport source (output valid, req_type, timer_id, delay, input ready);
	modport sink   (input valid, req_type, timer_id, delay, output ready);
endinterface

interface dtq_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [dtq_pkg::KIND_W-1:0] result_kind;
	logic [dtq_pkg::ID_W-1:0]   expired_id;
	logic [dtq_pkg::TTN_W-1:0]  time_to_next;
	logic                       last;

	modport source (output valid, result_kind, expired_id, time_to_next, last, input ready);
	modport sink   (input valid, result_kind, expired_id, time_to_next, last, output ready);
endinterface

### rtl/core/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// Deadline timer queue controller
// Sequences list search, removal, insertion and the yield pop loop.
// ----------------------------------------------------------------------------
module dtq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [dtq_pkg::REQ_W-1:0] req_type,
	output logic                      req_ready,
	input  dtq_pkg::dtq_sts_t         sts,
	output dtq_pkg::dtq_cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_REM_SCAN  = 3'd1;
	localparam logic [2:0] ST_REM_SHIFT = 3'd2;
	localparam logic [2:0] ST_INS_SCAN  = 3'd3;
	localparam logic [2:0] ST_INS_WRITE = 3'd4;
	localparam logic [2:0] ST_ACK       = 3'd5;
	localparam logic [2:0] ST_YIELD     = 3'd6;

	logic [2:0]                state_q;
	logic [2:0]                state_d;
	logic [dtq_pkg::REQ_W-1:0] req_q;
	logic                      is_start;

	assign req_ready = (state_q == ST_IDLE);
	assign is_start  = (req_q == dtq_pkg::REQ_START);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					unique case (req_type)
						dtq_pkg::REQ_START,
						dtq_pkg::REQ_STOP: state_d = ST_REM_SCAN;
						dtq_pkg::REQ_TICK: begin
							cmd.tick = 1'b1;
							state_d  = ST_ACK;
						end
						default: state_d = ST_YIELD;
					endcase
				end
			end
			ST_REM_SCAN: begin
				priority if (!sts.id_ok) begin
					state_d = ST_ACK;
				end else if (sts.at_end) begin
					if (is_start) begin
						cmd.pos_clr = 1'b1;
						state_d     = ST_INS_SCAN;
					end else begin
						state_d = ST_ACK;
					end
				end else if (sts.found) begin
					state_d = ST_REM_SHIFT;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			ST_REM_SHIFT: begin
				cmd.rem_shift = 1'b1;
				if (is_start) begin
					cmd.pos_clr = 1'b1;
					state_d     = ST_INS_SCAN;
				end else begin
					state_d = ST_ACK;
				end
			end
			ST_INS_SCAN: begin
				priority if (sts.ins_go) begin
					cmd.pos_inc = 1'b1;
				end else if (sts.full) begin
					state_d = ST_ACK;
				end else begin
					state_d = ST_INS_WRITE;
				end
			end
			ST_INS_WRITE: begin
				cmd.ins_write = 1'b1;
				state_d       = ST_ACK;
			end
			ST_ACK: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = dtq_pkg::KIND_ACK;
					state_d       = ST_IDLE;
				end
			end
			ST_YIELD: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.head_due) begin
						cmd.emit_kind = dtq_pkg::KIND_EXPIRED;
						cmd.rem_shift = 1'b1;
					end else begin
						cmd.emit_kind = dtq_pkg::KIND_DONE;
						state_d       = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q   <= dtq_pkg::REQ_START;
		end else begin
			state_q <= state_d;
			if (cmd.latch) begin
				req_q <= req_type;
			end
		end
	end

endmodule

### rtl/core/dtq_dpath.sv
// ----------------------------------------------------------------------------
// Deadline timer queue datapath
// Tick counter, ordered list cells, scan pointer and result register.
// ----------------------------------------------------------------------------
module dtq_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dtq_pkg::ID_W-1:0]    timer_id,
	input  logic [dtq_pkg::DELAY_W-1:0] delay,
	input  dtq_pkg::dtq_cmd_t           cmd,
	output dtq_pkg::dtq_sts_t           sts,
	dtq_rsp_if.source                   rsp
);

	logic [dtq_pkg::TICK_W-1:0] now_q;
	logic [dtq_pkg::CNT_W-1:0]  count_q;
	logic [dtq_pkg::CNT_W-1:0]  pos_q;
	logic [dtq_pkg::ID_W-1:0]   id_q;
	logic [dtq_pkg::TICK_W-1:0] dl_q;
	logic [dtq_pkg::ID_W-1:0]   ent_slot_q [dtq_pkg::NUM_TIMERS];
	logic [dtq_pkg::TICK_W-1:0] ent_dl_q   [dtq_pkg::NUM_TIMERS];

	logic                       out_valid_q;
	logic [dtq_pkg::KIND_W-1:0] out_kind_q;
	logic [dtq_pkg::ID_W-1:0]   out_id_q;
	logic [dtq_pkg::TTN_W-1:0]  out_ttn_q;
	logic                       out_last_q;

	logic [dtq_pkg::IDX_W-1:0]  pos_idx;
	logic [dtq_pkg::ID_W-1:0]   pos_slot;
	logic [dtq_pkg::TICK_W-1:0] pos_dl;
	logic [dtq_pkg::TICK_W-1:0] head_diff;
	logic [dtq_pkg::TTN_W-1:0]  ttn;

	assign pos_idx  = pos_q[dtq_pkg::IDX_W-1:0];
	assign pos_slot = ent_slot_q[pos_idx];
	assign pos_dl   = ent_dl_q[pos_idx];

	assign head_diff = ent_dl_q[0] - now_q;

	always_comb begin
		if (count_q == '0) begin
			ttn = '0;
		end else if (head_diff[dtq_pkg::TICK_W-1:dtq_pkg::TTN_W] != '0) begin
			ttn = '1;
		end else begin
			ttn = head_diff[dtq_pkg::TTN_W-1:0];
		end
	end

	assign sts.id_ok    = (int'(id_q) < dtq_pkg::NUM_TIMERS);
	assign sts.at_end   = (pos_q == count_q);
	assign sts.found    = (pos_q != count_q) && (pos_slot == id_q);
	assign sts.ins_go   = (pos_q != count_q) && (pos_dl < dl_q);
	assign sts.full     = (count_q == dtq_pkg::CNT_W'(dtq_pkg::NUM_TIMERS));
	assign sts.head_due = (count_q != '0) && !(now_q < ent_dl_q[0]);
	assign sts.out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q   <= '0;
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.tick) begin
				now_q <= now_q + dtq_pkg::TICK_W'(1);
			end
			if (cmd.latch || cmd.pos_clr) begin
				pos_q <= '0;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_q + dtq_pkg::CNT_W'(1);
			end
			if (cmd.rem_shift) begin
				count_q <= count_q - dtq_pkg::CNT_W'(1);
			end else if (cmd.ins_write) begin
				count_q <= count_q + dtq_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			id_q <= timer_id;
			dl_q <= now_q + dtq_pkg::TICK_W'(delay);
		end
		for (int i = 0; i < dtq_pkg::NUM_TIMERS; i++) begin
			if (cmd.rem_shift) begin
				if (i < dtq_pkg::NUM_TIMERS - 1 && dtq_pkg::CNT_W'(i) >= pos_q) begin
					ent_slot_q[i] <= ent_slot_q[(i + 1) % dtq_pkg::NUM_TIMERS];
					ent_dl_q[i]   <= ent_dl_q[(i + 1) % dtq_pkg::NUM_TIMERS];
				end
			end else if (cmd.ins_write) begin
				if (dtq_pkg::CNT_W'(i) == pos_q) begin
					ent_slot_q[i] <= id_q;
					ent_dl_q[i]   <= dl_q;
				end else if (i > 0 && dtq_pkg::CNT_W'(i) > pos_q) begin
					ent_slot_q[i] <= ent_slot_q[(i + dtq_pkg::NUM_TIMERS - 1) % dtq_pkg::NUM_TIMERS];
					ent_dl_q[i]   <= ent_dl_q[(i + dtq_pkg::NUM_TIMERS - 1) % dtq_pkg::NUM_TIMERS];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.emit_kind;
			out_id_q   <= (cmd.emit_kind == dtq_pkg::KIND_EXPIRED) ? ent_slot_q[0] : '0;
			out_ttn_q  <= (cmd.emit_kind == dtq_pkg::KIND_DONE) ? ttn : '0;
			out_last_q <= (cmd.emit_kind != dtq_pkg::KIND_EXPIRED);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_kind  = out_kind_q;
	assign rsp.expired_id   = out_id_q;
	assign rsp.time_to_next = out_ttn_q;
	assign rsp.last         = out_last_q;

endmodule

### rtl/core/deadline_timer_queue_core.sv
// Yield: one result per cycle per expired timer while the result channel accepts, then the closing result.
// Throughput: one request at a time; the list walk (one position a cycle) sets the rate.
// The next request is taken once the result register holds the final result.
// Reset clears the tick counter, list count, controller and result valid; list cells
// hold no reset and are only read below the count.
// ----------------------------------------------------------------------------
// Deadline timer queue core
// Ordered deadline list with a tick counter advanced by tick requests and yield of expired timers.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core (
	input  logic      clk,
	input  logic      arst_n,
	dtq_req_if.sink   req,
	dtq_rsp_if.source rsp
);

	dtq_pkg::dtq_cmd_t cmd;
	dtq_pkg::dtq_sts_t sts;
	logic              ctl_ready;

	assign req.ready = ctl_ready;

	dtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (ctl_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dtq_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.timer_id (req.timer_id),
		.delay    (req.delay),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule

### rtl/core/dtq_checker.sv
// ----------------------------------------------------------------------------
// Deadline timer queue checker
// Port-level properties of the timer queue core, bound to the top level.
// ----------------------------------------------------------------------------
`include "deadline_timer_queue_core_defines.svh"

module dtq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [dtq_pkg::KIND_W-1:0] rsp_kind,
	input logic [dtq_pkg::ID_W-1:0]   rsp_id,
	input logic [dtq_pkg::TTN_W-1:0]  rsp_ttn,
	input logic                       rsp_last
);

	`DTQ_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_id) && $stable(rsp_ttn) && $stable(rsp_last), "stalled result changed")
	`DTQ_ASSERT_NXT(a_busy_after_transfer, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")
	`DTQ_ASSERT_IMP(a_last_kind, clk, arst_n, rsp_valid, rsp_last == (rsp_kind != dtq_pkg::KIND_EXPIRED), "last flag disagrees with kind")
	`DTQ_ASSERT_IMP(a_zero_fields, clk, arst_n, rsp_valid, (rsp_kind == dtq_pkg::KIND_DONE || rsp_ttn == '0) && (rsp_kind == dtq_pkg::KIND_EXPIRED || rsp_id == '0), "unused result field not zero")

endmodule

bind deadline_timer_queue_core dtq_checker u_dtq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_kind  (rsp.result_kind),
	.rsp_id    (rsp.expired_id),
	.rsp_ttn   (rsp.time_to_next),
	.rsp_last  (rsp.last)
);

### tb/deadline_timer_queue_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deadline timer queue core testbench
// Drives start, stop, tick and yield requests through the request channel with
// bursty timing and checks every result against a local model of the ordered
// deadline list, while the result channel stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 300;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [dtq_pkg::KIND_W-1:0] kind;
		logic [dtq_pkg::ID_W-1:0]   id;
		logic [dtq_pkg::TTN_W-1:0]  ttn;
		logic                       last;
	} timer_result_t;

	logic clk;
	logic arst_n;

	dtq_req_if req_ch ();
	dtq_rsp_if rsp_ch ();

	deadline_timer_queue_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [dtq_pkg::TICK_W-1:0] tick_now;
	logic [dtq_pkg::TICK_W-1:0] slot_due [dtq_pkg::NUM_TIMERS];
	logic [dtq_pkg::ID_W-1:0]   due_order [dtq_pkg::NUM_TIMERS];
	int                         due_count;

	timer_result_t due_results [$];
	int            fault_count;
	int            cycle_count;
	int            burst_left;
	logic [15:0]   stall_pat;
	int            stall_age;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void push_result(input logic [dtq_pkg::KIND_W-1:0] kind,
			input logic [dtq_pkg::ID_W-1:0] id, input logic [dtq_pkg::TTN_W-1:0] ttn,
			input logic last);
		timer_result_t r;
		r.kind = kind;
		r.id   = id;
		r.ttn  = ttn;
		r.last = last;
		due_results.push_back(r);
	endfunction

	function automatic void unlink_timer(input logic [dtq_pkg::ID_W-1:0] slot);
		for (int i = 0; i < due_count; i++) begin
			if (due_order[i] == slot) begin
				for (int j = i; j < due_count - 1; j++)
					due_order[j] = due_order[j + 1];
				due_count--;
				return;
			end
		end
	endfunction

	function automatic void advance_timer_list(input logic [dtq_pkg::REQ_W-1:0] rt,
			input logic [dtq_pkg::ID_W-1:0] id, input logic [dtq_pkg::DELAY_W-1:0] dl);
		int                         pos;
		logic [dtq_pkg::ID_W-1:0]   head;
		logic [dtq_pkg::TICK_W-1:0] diff;
		logic [dtq_pkg::TTN_W-1:0]  ttn;
		case (rt)
			dtq_pkg::REQ_START: begin
				unlink_timer(id);
				slot_due[id] = tick_now + {32'd0, dl};
				if (due_count < dtq_pkg::NUM_TIMERS) begin
					pos = 0;
					while (pos < due_count && slot_due[due_order[pos]] < slot_due[id])
						pos++;
					for (int j = due_count; j > pos; j--)
						due_order[j] = due_order[j - 1];
					due_order[pos] = id;
					due_count++;
				end
				push_result(dtq_pkg::KIND_ACK, '0, '0, 1'b1);
			end
			dtq_pkg::REQ_STOP: begin
				unlink_timer(id);
				push_result(dtq_pkg::KIND_ACK, '0, '0, 1'b1);
			end
			dtq_pkg::REQ_TICK: begin
				tick_now = tick_now + 64'd1;
				push_result(dtq_pkg::KIND_ACK, '0, '0, 1'b1);
			end
			default: begin
				while (due_count > 0 && tick_now >= slot_due[due_order[0]]) begin
					head = due_order[0];
					unlink_timer(head);
					push_result(dtq_pkg::KIND_EXPIRED, head, '0, 1'b0);
				end
				ttn = '0;
				if (due_count > 0) begin
					diff = slot_due[due_order[0]] - tick_now;
					ttn  = (diff > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : diff[dtq_pkg::TTN_W-1:0];
				end
				push_result(dtq_pkg::KIND_DONE, '0, ttn, 1'b1);
			end
		endcase
	endfunction

	task automatic send_request(input logic [dtq_pkg::REQ_W-1:0] rt,
			input logic [dtq_pkg::ID_W-1:0] id, input logic [dtq_pkg::DELAY_W-1:0] dl);
		int idle_len;
		if (burst_left == 0) begin
			idle_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (idle_len != 0) begin
				req_ch.valid <= 1'b0;
				repeat (idle_len) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.timer_id <= id;
		req_ch.delay    <= dl;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		advance_timer_list(rt, id, dl);
		burst_left--;
	endtask

	// result side: compare each transfer, then advance the stall pattern
	always @(posedge clk) begin : result_check
		timer_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_results.size() == 0) begin
				$error("result with none outstanding: kind %0d id %0d ttn %0d last %0b",
					rsp_ch.result_kind, rsp_ch.expired_id, rsp_ch.time_to_next,
					rsp_ch.last);
				fault_count++;
			end else begin
				want = due_results.pop_front();
				if (rsp_ch.result_kind !== want.kind) begin
					$error("result_kind expected %0d actual %0d", want.kind,
						rsp_ch.result_kind);
					fault_count++;
				end
				if (rsp_ch.expired_id !== want.id) begin
					$error("expired_id expected %0d actual %0d", want.id,
						rsp_ch.expired_id);
					fault_count++;
				end
				if (rsp_ch.time_to_next !== want.ttn) begin
					$error("time_to_next expected %0d actual %0d", want.ttn,
						rsp_ch.time_to_next);
					fault_count++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last expected %0b actual %0b", want.last, rsp_ch.last);
					fault_count++;
				end
			end
		end
		stall_age++;
		if (stall_age >= 97) begin
			stall_age = 0;
			case ($urandom_range(0, 3))
				0, 1:    stall_pat = 16'hFFFF;
				2:       stall_pat = 16'h0001 << $urandom_range(0, 15);
				default: stall_pat = 16'($urandom_range(0, 16'hFFFF)) | 16'h0001;
			endcase
		end
		rsp_ch.ready <= stall_pat[0];
		stall_pat = {stall_pat[0], stall_pat[15:1]};
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("deadline_timer_queue_core verification failed");
			$finish;
		end
	end

	task automatic test_empty_queue;
		send_request(dtq_pkg::REQ_YIELD, 3'd0, 32'd0);
		send_request(dtq_pkg::REQ_TICK, 3'd7, 32'hFFFF_FFFF);
		send_request(dtq_pkg::REQ_STOP, 3'd5, 32'd0);
		send_request(dtq_pkg::REQ_YIELD, 3'd0, 32'd0);
	endtask

	task automatic test_equal_deadlines;
		send_request(dtq_pkg::REQ_START, 3'd3, 32'd2);
		send_request(dtq_pkg::REQ_START, 3'd1, 32'd2);
		send_request(dtq_pkg::REQ_START, 3'd6, 32'd0);
		send_request(dtq_pkg::REQ_YIELD, 3'd0, 32'd0);
		send_request(dtq_pkg::REQ_TICK, 3'd0, 32'd0);
		send_request(dtq_pkg::REQ_TICK, 3'd0, 32'd0);
		send_request(dtq_pkg::REQ_YIELD, 3'd0, 32'd0);
	endtask

	task automatic test_restart_and_stop;
		send_request(dtq_pkg::REQ_START, 3'd2, 32'd5);
		send_request(dtq_pkg::REQ_START, 3'd2, 32'd1);
		send_request(dtq_pkg::REQ_YIELD, 3'd0, 32'd0);
		send_request(dtq_pkg::REQ_STOP, 3'd2, 32'd0);
		send_request(dtq_pkg::REQ_STOP, 3'd2, 32'd0);
	endtask

	task automatic test_saturated_wait;
		send_request(dtq_pkg::REQ_START, 3'd7, 32'hFFFF_FFFF);
		send_request(dtq_pkg::REQ_YIELD, 3'd0, 32'd0);
		send_request(dtq_pkg::REQ_START, 3'd0, 32'h7FFF_FFFF);
		send_request(dtq_pkg::REQ_START, 3'd4, 32'h8000_0000);
		send_request(dtq_pkg::REQ_YIELD, 3'd0, 32'd0);
		send_request(dtq_pkg::REQ_STOP, 3'd0, 32'd0);
		send_request(dtq_pkg::REQ_STOP, 3'd4, 32'd0);
		send_request(dtq_pkg::REQ_STOP, 3'd7, 32'd0);
	endtask

	task automatic test_full_list;
		for (int i = dtq_pkg::NUM_TIMERS - 1; i >= 0; i--)
			send_request(dtq_pkg::REQ_START, dtq_pkg::ID_W'(i), 32'd0);
		send_request(dtq_pkg::REQ_YIELD, 3'd0, 32'd0);
	endtask

	task automatic test_random_traffic;
		int                          pick;
		logic [dtq_pkg::DELAY_W-1:0] dl;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0:       dl = $urandom;
				1:       dl = $urandom_range(32'h7FFF_FFF0, 32'h8000_0010);
				2:       dl = $urandom_range(0, 40);
				default: dl = $urandom_range(0, 6);
			endcase
			if (pick < 35)
				send_request(dtq_pkg::REQ_START, dtq_pkg::ID_W'($urandom_range(0, 7)), dl);
			else if (pick < 45)
				send_request(dtq_pkg::REQ_STOP, dtq_pkg::ID_W'($urandom_range(0, 7)),
					$urandom);
			else if (pick < 75)
				send_request(dtq_pkg::REQ_TICK, dtq_pkg::ID_W'($urandom_range(0, 7)),
					$urandom);
			else
				send_request(dtq_pkg::REQ_YIELD, dtq_pkg::ID_W'($urandom_range(0, 7)),
					$urandom);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = dtq_pkg::REQ_TICK;
		req_ch.timer_id = '0;
		req_ch.delay    = '0;
		rsp_ch.ready    = 1'b0;
		tick_now        = '0;
		due_count       = 0;
		fault_count     = 0;
		cycle_count     = 0;
		burst_left      = 0;
		stall_pat       = 16'hFFFF;
		stall_age       = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_equal_deadlines();
		test_restart_and_stop();
		test_saturated_wait();
		test_full_list();
		test_random_traffic();

		req_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && due_results.size() == 0)
			$display("deadline_timer_queue_core verification clean");
		else
			$display("deadline_timer_queue_core verification failed");
		$finish;
	end

endmodule
